[hw/rtl/sks_pkg.sv]
// shared types, constants and command/status structs for the sorted key set
// no dependencies
package sks_pkg;

  localparam int Capacity = 64;
  localparam int IDX_W    = $clog2(Capacity);
  localparam int CNT_W    = $clog2(Capacity + 1);
  localparam int KEY_W    = 32;

  localparam logic [1:0] KIND_FIND   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic success;
    logic full_res;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_MID,
    RD_LO,
    RD_PTR_DN,
    RD_PTR_UP
  } rd_src_t;

  typedef enum logic {
    WR_SHIFT,
    WR_KEY
  } wr_src_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_src_t rd_src;
    logic    step;
    logic    ptr_from_cnt;
    logic    ptr_from_lo;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    wr_en;
    wr_src_t wr_src;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_res;
    logic    res_success;
    logic    res_full;
    logic    rsp_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       more;
    logic       present;
    logic       full;
    logic       ptr_at_lo;
    logic       ptr_last;
    logic       rsp_busy;
  } status_t;

endpackage

[hw/rtl/sks_ctrl.sv]
// controller state machine for the sorted key set
// depends on sks_pkg
module sks_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sks_pkg::status_t stat,
  output sks_pkg::cmd_t   cmd
);
  import sks_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SRCH_RD;
        end
      end
      // binary search for the first key not below the request key
      ST_SRCH_RD: begin
        if (stat.more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_MID;
          state_next = ST_SRCH_CMP;
        end else begin
          state_next = ST_CHK_RD;
        end
      end
      ST_SRCH_CMP: begin
        cmd.step   = 1'b1;
        state_next = ST_SRCH_RD;
      end
      ST_CHK_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_LO;
        state_next = ST_CHK_CMP;
      end
      // decide on the operation once presence is known
      ST_CHK_CMP: begin
        cmd.set_res = 1'b1;
        state_next  = ST_DONE;
        priority if (stat.kind == KIND_FIND) begin
          cmd.res_success = stat.present;
        end else if (stat.kind == KIND_INSERT) begin
          if (!stat.present) begin
            if (stat.full) begin
              cmd.res_full = 1'b1;
            end else begin
              cmd.set_res      = 1'b0;
              cmd.ptr_from_cnt = 1'b1;
              state_next       = ST_INS_RD;
            end
          end
        end else if (stat.kind == KIND_DELETE) begin
          if (stat.present) begin
            cmd.set_res     = 1'b0;
            cmd.ptr_from_lo = 1'b1;
            state_next      = ST_DEL_RD;
          end
        end else begin
          cmd.res_success = 1'b0;
        end
      end
      // open a slot at the insert position, top entry first
      ST_INS_RD: begin
        if (stat.ptr_at_lo) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_src      = WR_KEY;
          cmd.cnt_inc     = 1'b1;
          cmd.set_res     = 1'b1;
          cmd.res_success = 1'b1;
          state_next      = ST_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_PTR_DN;
          state_next = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_SHIFT;
        cmd.ptr_dec = 1'b1;
        state_next  = ST_INS_RD;
      end
      // close the gap left by the removed key
      ST_DEL_RD: begin
        if (stat.ptr_last) begin
          cmd.cnt_dec     = 1'b1;
          cmd.set_res     = 1'b1;
          cmd.res_success = 1'b1;
          state_next      = ST_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_PTR_UP;
          state_next = ST_DEL_WR;
        end
      end
      ST_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_SHIFT;
        cmd.ptr_inc = 1'b1;
        state_next  = ST_DEL_RD;
      end
      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!stat.rsp_busy) begin
          cmd.rsp_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/sks_datapath.sv]
// key memory, search bounds, shift pointer, count and output register
// depends on sks_pkg
module sks_datapath (
  input  logic             clk,
  input  logic             rst,
  input  sks_pkg::req_t    req,
  input  sks_pkg::cmd_t    cmd,
  output sks_pkg::status_t stat,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output sks_pkg::rsp_t    rsp
);
  import sks_pkg::*;

  logic [KEY_W-1:0]        mem [Capacity];
  logic [KEY_W-1:0]        rd_data;
  logic signed [KEY_W-1:0] key;
  logic [1:0]              kind;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hi;
  logic [CNT_W-1:0]        ptr;
  logic [CNT_W-1:0]        count;
  logic                    res_success;
  logic                    res_full;

  logic [CNT_W:0]          bound_sum;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W-1:0]        ptr_dn;
  logic [CNT_W-1:0]        ptr_up;
  logic [CNT_W-1:0]        rd_sel;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        wr_addr;
  logic [KEY_W-1:0]        wr_data;

  // address and data selection
  always_comb begin
    bound_sum = {1'b0, lo} + {1'b0, hi};
    mid       = bound_sum[CNT_W:1];
    ptr_dn    = ptr - CNT_W'(1);
    ptr_up    = ptr + CNT_W'(1);
    unique case (cmd.rd_src)
      RD_MID:    rd_sel = mid;
      RD_LO:     rd_sel = lo;
      RD_PTR_DN: rd_sel = ptr_dn;
      RD_PTR_UP: rd_sel = ptr_up;
      default:   rd_sel = lo;
    endcase
    rd_addr = rd_sel[IDX_W-1:0];
    if (cmd.wr_src == WR_KEY) begin
      wr_addr = lo[IDX_W-1:0];
      wr_data = key;
    end else begin
      wr_addr = ptr[IDX_W-1:0];
      wr_data = rd_data;
    end
  end

  // key memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // request capture, search bounds, shift pointer and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key  <= req.key;
      kind <= req.kind;
      lo   <= '0;
      hi   <= count;
    end else if (cmd.step) begin
      if ($signed(rd_data) < key) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
    priority if (cmd.ptr_from_cnt) begin
      ptr <= count;
    end else if (cmd.ptr_from_lo) begin
      ptr <= lo;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr_dn;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr_up;
    end
    if (cmd.set_res) begin
      res_success <= cmd.res_success;
      res_full    <= cmd.res_full;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      rsp.success  <= res_success;
      rsp.full_res <= res_full;
    end
  end

  // status toward the controller
  always_comb begin
    stat.kind      = kind;
    stat.more      = lo < hi;
    stat.present   = (lo < count) && ($signed(rd_data) == key);
    stat.full      = count == CNT_W'(Capacity);
    stat.ptr_at_lo = ptr == lo;
    stat.ptr_last  = ptr_up == count;
    stat.rsp_busy  = rsp_valid && !rsp_ready;
  end

endmodule

[hw/rtl/sorted_key_set_core.sv]
// Sorted set of distinct signed 32-bit keys, up to 64 held in ascending order
// in a memory with one write port and one registered read port. One request
// (find, insert, delete) is handled at a time and gives one response. A
// request is taken, then runs a binary search of at most ceil(log2(n+1))
// halvings for n held keys, each a read and a compare; the search is left and
// the found entry is read and checked. An insert then moves every key above
// the insert point up by one and a delete moves every key above the removed
// one down, each moved key read and then written, after which the new key is
// written or the count dropped. Then the response is handed to the output
// register, which shows it from the next cycle on. The set is empty after
// reset and needs no clearing pass. A response that waits in the output
// register does not stop the next request being taken; that request then
// holds its response until the register frees.
// depends on sks_pkg, sks_ctrl, sks_datapath
module sorted_key_set_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sks_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sks_pkg::rsp_t rsp
);
  import sks_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // control
  sks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and compare
  sks_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

[hw/rtl/sks_checker.sv]
// port-level checks for the sorted key set, bound to the top level
// depends on sks_pkg and sorted_key_set_core
module sks_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input sks_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input sks_pkg::rsp_t rsp
);
  import sks_pkg::*;

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // a refused insert never also reports success
  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.full_res && rsp.success))
    else $error("full and success both set");

  // one request at a time: busy right after a transfer
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // a new response appears only at the end of a request
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("response without a request in flight");

endmodule

bind sorted_key_set_core sks_checker u_sks_checker (.*);

[dv/sorted_key_set_core_tb.sv]
// self-checking testbench for sorted_key_set_core: directed table, then random traffic
// depends on sks_pkg and sorted_key_set_core
`timescale 1ns / 100ps

module sorted_key_set_core_tb;
  import sks_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 1100;
  localparam int         DRAIN_CYCLES = 400;
  localparam int         KMIN         = 32'sh8000_0000;
  localparam int         KMAX         = 32'sh7fff_ffff;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } traffic_mode_t;

  typedef struct {
    logic [1:0] kind;
    int         key;
    bit         typed;
    rsp_t       answer;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // answer typed in the table travels with the request
  bit   row_typed = 1'b0;
  rsp_t row_answer = '0;

  // shadow copy of the set, ascending
  int   held_keys[$];
  rsp_t pending_answers[$];
  row_t directed_rows[$];
  int   key_pool[64];

  traffic_mode_t traffic_mode = MODE_MIXED;
  int   block_left = 0;
  bit   sender_eager = 1'b0;

  int   errors = 0;
  int   kind_count[4];
  int   success_count = 0;
  int   full_count = 0;
  int   peak_size = 0;

  sorted_key_set_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // idle length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // update the shadow set with one request and give its answer
  function automatic rsp_t apply_request(req_t r);
    rsp_t ans;
    int   k;
    int   pos;
    bit   present;
    ans = '0;
    k = r.key;
    pos = 0;
    while (pos < held_keys.size() && held_keys[pos] < k) pos++;
    present = (pos < held_keys.size()) && (held_keys[pos] == k);
    case (r.kind)
      KIND_FIND: begin
        ans.success = present;
      end
      KIND_INSERT: begin
        if (!present) begin
          if (held_keys.size() >= Capacity) begin
            ans.full_res = 1'b1;
          end else begin
            held_keys.insert(pos, k);
            ans.success = 1'b1;
          end
        end
      end
      KIND_DELETE: begin
        if (present) begin
          held_keys.delete(pos);
          ans.success = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // key choice: held keys for hits, a pool for collisions, fresh values for misses
  function automatic int pick_key(int fresh_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < fresh_pct) return $urandom();
    r = $urandom_range(0, 99);
    if (r < 40 && held_keys.size() > 0) return held_keys[$urandom_range(0, held_keys.size() - 1)];
    if (r < 92) return key_pool[$urandom_range(0, 63)];
    case ($urandom_range(0, 6))
      0: return KMIN;
      1: return KMIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return KMAX - 1;
      default: return KMAX;
    endcase
  endfunction

  // random request, traffic shaped in blocks that fill, drain or mix the set
  function automatic row_t random_row();
    row_t row;
    int   r;
    if (block_left == 0) begin
      r = $urandom_range(0, 99);
      traffic_mode = (r < 40) ? MODE_FILL : (r < 70) ? MODE_DRAIN : MODE_MIXED;
      block_left = $urandom_range(60, 140);
      sender_eager = ($urandom_range(0, 4) == 0);
    end
    block_left--;
    row.typed = 1'b0;
    row.answer = '0;
    r = $urandom_range(0, 99);
    case (traffic_mode)
      MODE_FILL: begin
        row.kind = (r < 80) ? KIND_INSERT : (r < 88) ? KIND_FIND :
                   (r < 96) ? KIND_DELETE : KIND_UNUSED;
        row.key = pick_key((row.kind == KIND_INSERT) ? 50 : 10);
      end
      MODE_DRAIN: begin
        row.kind = (r < 75) ? KIND_DELETE : (r < 87) ? KIND_FIND :
                   (r < 96) ? KIND_INSERT : KIND_UNUSED;
        row.key = pick_key(5);
      end
      default: begin
        row.kind = (r < 33) ? KIND_FIND : (r < 66) ? KIND_INSERT :
                   (r < 96) ? KIND_DELETE : KIND_UNUSED;
        row.key = pick_key(15);
      end
    endcase
    return row;
  endfunction

  task automatic add_row(logic [1:0] kind, int key, bit typed, bit success, bit full_res);
    row_t row;
    row.kind = kind;
    row.key = key;
    row.typed = typed;
    row.answer.success = success;
    row.answer.full_res = full_res;
    directed_rows.push_back(row);
  endtask

  // response side: ready runs broken by stalls, sometimes a long run without any
  initial begin : rsp_stall_gen
    int run_len;
    int stall_len;
    @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      rsp_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // predict on each request transfer, check on each response transfer
  always @(posedge clk) begin : answer_check
    rsp_t predicted;
    rsp_t wanted;
    if (!rst) begin
      if (req_valid && req_ready) begin
        predicted = apply_request(req);
        pending_answers.push_back(row_typed ? row_answer : predicted);
        kind_count[req.kind]++;
        if (predicted.success) success_count++;
        if (predicted.full_res) full_count++;
        if (held_keys.size() > peak_size) peak_size = held_keys.size();
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_answers.size() == 0) begin
          $error("response transfer with no request outstanding");
          errors++;
        end else begin
          wanted = pending_answers.pop_front();
          if (rsp.success !== wanted.success) begin
            $error("success: expected %0d actual %0d", wanted.success, rsp.success);
            errors++;
          end
          if (rsp.full_res !== wanted.full_res) begin
            $error("full_res: expected %0d actual %0d", wanted.full_res, rsp.full_res);
            errors++;
          end
        end
      end
    end
  end

  // request side and end of run
  initial begin : request_driver
    row_t item;
    int   gap;
    int   n_total;

    for (int i = 0; i < 64; i++) begin
      key_pool[i] = (i < 32) ? $urandom_range(0, 80) - 40 : $urandom();
    end

    // empty set, extremes, duplicates, unused kind, missing keys
    add_row(KIND_FIND,   0,    1, 0, 0);
    add_row(KIND_DELETE, KMAX, 1, 0, 0);
    add_row(KIND_FIND,   KMIN, 1, 0, 0);
    add_row(KIND_UNUSED, 0,    1, 0, 0);
    add_row(KIND_INSERT, KMIN, 1, 1, 0);
    add_row(KIND_INSERT, KMAX, 1, 1, 0);
    add_row(KIND_INSERT, KMIN, 1, 0, 0);
    add_row(KIND_FIND,   KMIN, 1, 1, 0);
    add_row(KIND_FIND,   KMAX, 1, 1, 0);
    add_row(KIND_FIND,   0,    1, 0, 0);
    add_row(KIND_INSERT, 0,    0, 0, 0);
    add_row(KIND_INSERT, -1,   0, 0, 0);
    add_row(KIND_INSERT, 1,    0, 0, 0);
    add_row(KIND_FIND,   -1,   0, 0, 0);
    add_row(KIND_DELETE, 0,    0, 0, 0);
    add_row(KIND_FIND,   0,    0, 0, 0);
    add_row(KIND_DELETE, 0,    1, 0, 0);
    add_row(KIND_UNUSED, KMAX, 1, 0, 0);
    add_row(KIND_DELETE, KMIN, 0, 0, 0);
    add_row(KIND_DELETE, KMAX, 0, 0, 0);
    add_row(KIND_FIND,   32'sh5555_5555, 0, 0, 0);
    add_row(KIND_INSERT, 32'shaaaa_aaaa, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    n_total = directed_rows.size() + RANDOM_ITEMS;
    for (int i = 0; i < n_total; i++) begin
      item = (i < directed_rows.size()) ? directed_rows[i] : random_row();
      gap = (i == 0) ? 1 : sender_eager ? 0 : pick_gap();
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req_valid <= 1'b1;
      req.kind <= item.kind;
      req.key <= item.key;
      row_typed <= item.typed;
      row_answer <= item.answer;
      do @(posedge clk); while (!req_ready);
    end
    req_valid <= 1'b0;

    // let every answer come back, then watch for strays
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d find, %0d insert, %0d delete, %0d unused kind",
             n_total, kind_count[KIND_FIND], kind_count[KIND_INSERT],
             kind_count[KIND_DELETE], kind_count[KIND_UNUSED]);
    $display("%0d succeeded, %0d inserts refused at capacity, peak occupancy %0d of %0d",
             success_count, full_count, peak_size, Capacity);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sks_pkg.sv
hw/rtl/sks_ctrl.sv
hw/rtl/sks_datapath.sv
hw/rtl/sorted_key_set_core.sv
hw/rtl/sks_checker.sv
dv/sorted_key_set_core_tb.sv
